// ===== rtl/rldpi_pkg.sv =====
// ----------------------------------------------------------------------------
// rldpi_pkg
// Shared types, codes and constants of the raster line scaler.
// ----------------------------------------------------------------------------
package rldpi_pkg;

	localparam int MAX_REPEAT  = 16;
	localparam int LINE_PIXELS = 4096;
	localparam int MAX_RESULTS = 16;
	localparam int REP_CAP     = (MAX_REPEAT < MAX_RESULTS) ? MAX_REPEAT : MAX_RESULTS;
	localparam int REP_W       = $clog2(REP_CAP + 1);

	localparam int DPI_W   = 11;
	localparam int PW_W    = 13;
	localparam int PH_W    = 14;
	localparam int COL_W   = 12;
	localparam int WCOL_W  = 13;
	localparam int ACC_W   = 12;
	localparam int WRK_W   = 13;
	localparam int QUOT_W  = 12;
	localparam int ROW_W   = 14;
	localparam int BYTE_W  = 8;

	localparam int ALU_W = 24;
	localparam int OPB_W = 14;
	localparam int SH_W  = 4;

	localparam logic [SH_W-1:0] MOD_SH = SH_W'(WRK_W - 1);
	localparam logic [SH_W-1:0] DIV_SH = SH_W'(QUOT_W - 1);

	localparam logic [WCOL_W-1:0] WCOL_MAX = {WCOL_W{1'b1}};
	localparam logic [ROW_W-1:0]  ROWS_MAX = {ROW_W{1'b1}};

	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	localparam logic [DPI_W-1:0] RST_SRC_X  = 11'd300;
	localparam logic [DPI_W-1:0] RST_SRC_Y  = 11'd300;
	localparam logic [DPI_W-1:0] RST_PAGE_X = 11'd300;
	localparam logic [DPI_W-1:0] RST_PAGE_Y = 11'd300;
	localparam logic [PW_W-1:0]  RST_PAGE_W = 13'd2479;
	localparam logic [PH_W-1:0]  RST_PAGE_H = 14'd3508;

	typedef enum logic [2:0] {
		REG_SRC_X  = 3'd0,
		REG_SRC_Y  = 3'd1,
		REG_PAGE_X = 3'd2,
		REG_PAGE_Y = 3'd3,
		REG_PAGE_W = 3'd4,
		REG_PAGE_H = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		CMD_PIXEL = 2'd0,
		CMD_LINE  = 2'd1,
		CMD_EJECT = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_PIXEL = 2'd0,
		KIND_LINE  = 2'd1,
		KIND_BLANK = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PX_ADD,
		ST_PX_LOOP,
		ST_PX_MOD,
		ST_LN_ADD,
		ST_LN_DIV,
		ST_LN_OUT,
		ST_EJ_OUT
	} state_t;

	typedef struct packed {
		logic [DPI_W-1:0] src_x;
		logic [DPI_W-1:0] src_y;
		logic [DPI_W-1:0] page_x;
		logic [DPI_W-1:0] page_y;
		logic [PW_W-1:0]  page_w;
		logic [PH_W-1:0]  page_h;
	} cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] blue;
		logic [BYTE_W-1:0] green;
		logic [BYTE_W-1:0] red;
	} rgb_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [COL_W-1:0] column;
		rgb_t             rgb;
		logic [ROW_W-1:0] line_total;
		logic [ROW_W-1:0] first_row;
		logic             last;
	} res_t;

	typedef struct packed {
		logic             sub;
		logic [ALU_W-1:0] a;
		logic [OPB_W-1:0] b;
		logic [SH_W-1:0]  sh;
	} alu_req_t;

	typedef struct packed {
		logic [ALU_W-1:0] res;
		logic             cout;
	} alu_rsp_t;

	function automatic logic [PW_W-1:0] usable_width(input logic [PW_W-1:0] page_w);
		logic [PW_W+2:0] wide;
		wide = {3'b000, page_w};
		if (wide < (PW_W+3)'(LINE_PIXELS))
			return page_w;
		else
			return PW_W'(LINE_PIXELS);
	endfunction

endpackage

// ===== rtl/raster_line_dpi_scaler_unit.sv =====
// ----------------------------------------------------------------------------
// raster_line_dpi_scaler_unit
// Nearest-neighbor raster line scaler: source pixels to page pixel writes,
// line ends to row copy counts, eject to blank page fill.
// ----------------------------------------------------------------------------
// channel   direction  handshake                 payload
// s_axis    in         s_axis_tvalid/tready      tuser command, tdata rgb
// m_axis    out        m_axis_tvalid/tready      tuser kind, tlast, tdata
// apb       in/out     psel/penable/pwrite       paddr, pwdata, prdata
//
// Pixel: add, loop over column overflows, then remainder reduction when the
// repeat limit stops the loop. Line end: add, divide, output. Eject: output.
// All arithmetic runs through one shared 24-bit add/subtract-shift unit.
// Reset clears scaler state and loads the register defaults.
// A stalled result holds the sequencer; one finished result may wait in the
// output register while the next request is taken.
// ----------------------------------------------------------------------------
module raster_line_dpi_scaler_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [23:0]                     s_axis_tdata,  // in_red, in_green, in_blue
	input  logic [1:0]                      s_axis_tuser,  // command
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// column[11:0], out_red, out_green, out_blue, line_total[13:0], first_row[13:0]
	output logic [63:0]                     m_axis_tdata,
	output logic [1:0]                      m_axis_tuser,  // kind
	output logic                            m_axis_tlast,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [rldpi_pkg::PADDR_W-1:0]   paddr,
	input  logic [rldpi_pkg::PDATA_W-1:0]   pwdata,
	output logic [rldpi_pkg::PDATA_W-1:0]   prdata,
	output logic                            pready
);
	import rldpi_pkg::*;

	cfg_t     cfg;
	res_t     res;
	rgb_t     s_rgb;
	alu_req_t alu_req;
	alu_rsp_t alu_rsp;

	assign s_rgb = s_axis_tdata;

	rldpi_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rldpi_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	rldpi_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.s_valid (s_axis_tvalid),
		.s_ready (s_axis_tready),
		.s_cmd   (s_axis_tuser),
		.s_rgb   (s_rgb),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.m_res   (res),
		.alu_req (alu_req),
		.alu_rsp (alu_rsp)
	);

	assign m_axis_tdata = {res.first_row, res.line_total, res.rgb, res.column};
	assign m_axis_tuser = res.kind;
	assign m_axis_tlast = res.last;

	logic [PW_W-1:0] usable;
	assign usable = usable_width(cfg.page_w);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready &&
		(s_axis_tuser == CMD_PIXEL || s_axis_tuser == CMD_LINE)) |=> !s_axis_tready)
		else $error("request accepted while sequencer busy");

	a_pixel_in_width: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == KIND_PIXEL) |->
		(PW_W'(m_axis_tdata[11:0]) < usable))
		else $error("pixel write beyond usable line width");

	a_line_ends_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser != KIND_PIXEL) |-> m_axis_tlast)
		else $error("line or blank result without last");

	a_status_zero_rgb: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser != KIND_PIXEL) |-> (m_axis_tdata[35:12] == '0))
		else $error("status result carries pixel bytes");

endmodule

// ===== rtl/rldpi_alu.sv =====
// ----------------------------------------------------------------------------
// rldpi_alu
// Shared add / subtract unit with a left-shifted second operand.
// ----------------------------------------------------------------------------
module rldpi_alu (
	input  rldpi_pkg::alu_req_t req,
	output rldpi_pkg::alu_rsp_t rsp
);
	import rldpi_pkg::*;

	logic [ALU_W-1:0] b_sh;
	logic [ALU_W-1:0] b_op;
	logic [ALU_W:0]   sum;

	always_comb begin
		b_sh    = ALU_W'(req.b) << req.sh;
		b_op    = req.sub ? ~b_sh : b_sh;
		sum     = {1'b0, req.a} + {1'b0, b_op} + {{ALU_W{1'b0}}, req.sub};
		rsp.res  = sum[ALU_W-1:0];
		rsp.cout = sum[ALU_W];
	end

endmodule

// ===== rtl/rldpi_cfg.sv =====
// ----------------------------------------------------------------------------
// rldpi_cfg
// APB register file holding resolutions and page size.
// ----------------------------------------------------------------------------
module rldpi_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [rldpi_pkg::PADDR_W-1:0]   paddr,
	input  logic [rldpi_pkg::PDATA_W-1:0]   pwdata,
	output logic [rldpi_pkg::PDATA_W-1:0]   prdata,
	output logic                            pready,
	output rldpi_pkg::cfg_t                 cfg
);
	import rldpi_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign idx    = paddr[PADDR_W-1:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.src_x  <= RST_SRC_X;
			cfg_q.src_y  <= RST_SRC_Y;
			cfg_q.page_x <= RST_PAGE_X;
			cfg_q.page_y <= RST_PAGE_Y;
			cfg_q.page_w <= RST_PAGE_W;
			cfg_q.page_h <= RST_PAGE_H;
		end else if (wr_en) begin
			case (idx)
				REG_SRC_X:  cfg_q.src_x  <= pwdata[DPI_W-1:0];
				REG_SRC_Y:  cfg_q.src_y  <= pwdata[DPI_W-1:0];
				REG_PAGE_X: cfg_q.page_x <= pwdata[DPI_W-1:0];
				REG_PAGE_Y: cfg_q.page_y <= pwdata[DPI_W-1:0];
				REG_PAGE_W: cfg_q.page_w <= pwdata[PW_W-1:0];
				REG_PAGE_H: cfg_q.page_h <= pwdata[PH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_SRC_X:  prdata = PDATA_W'(cfg_q.src_x);
			REG_SRC_Y:  prdata = PDATA_W'(cfg_q.src_y);
			REG_PAGE_X: prdata = PDATA_W'(cfg_q.page_x);
			REG_PAGE_Y: prdata = PDATA_W'(cfg_q.page_y);
			REG_PAGE_W: prdata = PDATA_W'(cfg_q.page_w);
			REG_PAGE_H: prdata = PDATA_W'(cfg_q.page_h);
			default:    prdata = '0;
		endcase
	end

endmodule

// ===== rtl/rldpi_ctrl.sv =====
// ----------------------------------------------------------------------------
// rldpi_ctrl
// Sequencer, scaler state and result register around the shared unit.
// ----------------------------------------------------------------------------
module rldpi_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  rldpi_pkg::cfg_t     cfg,
	input  logic                s_valid,
	output logic                s_ready,
	input  logic [1:0]          s_cmd,
	input  rldpi_pkg::rgb_t     s_rgb,
	output logic                m_valid,
	input  logic                m_ready,
	output rldpi_pkg::res_t     m_res,
	output rldpi_pkg::alu_req_t alu_req,
	input  rldpi_pkg::alu_rsp_t alu_rsp
);
	import rldpi_pkg::*;

	state_t             state_q, state_d;
	logic [WRK_W-1:0]   wrk_q;
	logic [QUOT_W-1:0]  quot_q;
	logic [SH_W-1:0]    sh_q;
	logic [REP_W-1:0]   reps_q;
	logic               pend_q;
	logic [COL_W-1:0]   pend_col_q;
	rgb_t               pix_q;
	logic [ACC_W-1:0]   col_acc_q;
	logic [WCOL_W-1:0]  wc_q;
	logic [ACC_W-1:0]   row_acc_q;
	logic [ROW_W-1:0]   rows_q;
	logic               active_q;
	res_t               out_q;
	logic               out_valid_q;

	logic [DPI_W-1:0]   sx_eff, sy_eff;
	logic [PW_W-1:0]    usable;
	logic [WCOL_W-1:0]  pad;
	logic               ofree, ge, cont, wc_in, sh_zero, starts_page;
	logic               adv, load_out;
	logic [ROW_W-1:0]   blanks;
	logic [ROW_W-1:0]   rows_sum;
	res_t               out_d;

	always_comb begin
		sx_eff      = (cfg.src_x == '0) ? DPI_W'(1) : cfg.src_x;
		sy_eff      = (cfg.src_y == '0) ? DPI_W'(1) : cfg.src_y;
		usable      = usable_width(cfg.page_w);
		pad         = (wc_q < usable) ? wc_q : usable;
		ofree       = !out_valid_q || m_ready;
		ge          = alu_rsp.cout;
		cont        = ge && (reps_q < REP_W'(REP_CAP));
		wc_in       = wc_q < usable;
		sh_zero     = sh_q == '0;
		starts_page = (s_cmd == CMD_PIXEL) || (s_cmd == CMD_LINE);
		blanks      = ge ? alu_rsp.res[ROW_W-1:0] : '0;
		rows_sum    = (alu_rsp.res[ALU_W-1:ROW_W] != '0) ? ROWS_MAX
		                                                 : alu_rsp.res[ROW_W-1:0];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_valid) begin
					case (s_cmd)
						CMD_PIXEL: state_d = ST_PX_ADD;
						CMD_LINE:  state_d = ST_LN_ADD;
						CMD_EJECT: state_d = active_q ? ST_EJ_OUT : ST_IDLE;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_PX_ADD: state_d = ST_PX_LOOP;
			ST_PX_LOOP: begin
				if (!(pend_q && !ofree) && !cont)
					state_d = ge ? ST_PX_MOD : ST_IDLE;
			end
			ST_PX_MOD: if (sh_zero) state_d = ST_IDLE;
			ST_LN_ADD: state_d = ST_LN_DIV;
			ST_LN_DIV: if (sh_zero) state_d = ST_LN_OUT;
			ST_LN_OUT: if (ofree) state_d = ST_IDLE;
			ST_EJ_OUT: if (ofree) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_ready  = 1'b0;
		alu_req  = '0;
		adv      = 1'b1;
		load_out = 1'b0;
		out_d    = '0;
		case (state_q)
			ST_IDLE: s_ready = 1'b1;
			ST_PX_ADD: begin
				alu_req.a = ALU_W'(col_acc_q);
				alu_req.b = OPB_W'(cfg.page_x);
			end
			ST_PX_LOOP: begin
				alu_req.sub = 1'b1;
				alu_req.a   = ALU_W'(wrk_q);
				alu_req.b   = OPB_W'(sx_eff);
				adv         = !(pend_q && !ofree);
				load_out    = pend_q && ofree;
				out_d.kind   = KIND_PIXEL;
				out_d.column = pend_col_q;
				out_d.rgb    = pix_q;
				out_d.last   = !(cont && wc_in);
			end
			ST_PX_MOD: begin
				alu_req.sub = 1'b1;
				alu_req.a   = ALU_W'(wrk_q);
				alu_req.b   = OPB_W'(sx_eff);
				alu_req.sh  = sh_q;
			end
			ST_LN_ADD: begin
				alu_req.a = ALU_W'(row_acc_q);
				alu_req.b = OPB_W'(cfg.page_y);
			end
			ST_LN_DIV: begin
				alu_req.sub = 1'b1;
				alu_req.a   = ALU_W'(wrk_q);
				alu_req.b   = OPB_W'(sy_eff);
				alu_req.sh  = sh_q;
			end
			ST_LN_OUT: begin
				alu_req.a        = ALU_W'(rows_q);
				alu_req.b        = OPB_W'(quot_q);
				adv              = ofree;
				load_out         = ofree;
				out_d.kind       = KIND_LINE;
				out_d.column     = pad[COL_W-1:0];
				out_d.line_total = ROW_W'(quot_q);
				out_d.first_row  = rows_q;
				out_d.last       = 1'b1;
			end
			ST_EJ_OUT: begin
				alu_req.sub      = 1'b1;
				alu_req.a        = ALU_W'(cfg.page_h);
				alu_req.b        = rows_q;
				adv              = ofree;
				load_out         = ofree;
				out_d.kind       = KIND_BLANK;
				out_d.line_total = blanks;
				out_d.first_row  = rows_q;
				out_d.last       = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			active_q    <= 1'b0;
			rows_q      <= '0;
			col_acc_q   <= '0;
			wc_q        <= '0;
			row_acc_q   <= '0;
			reps_q      <= '0;
			pend_q      <= 1'b0;
			sh_q        <= '0;
		end else begin
			state_q <= state_d;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (m_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					reps_q <= '0;
					pend_q <= 1'b0;
					if (s_valid && starts_page && !active_q) begin
						rows_q   <= '0;
						active_q <= 1'b1;
					end
				end
				ST_PX_LOOP: begin
					if (adv) begin
						if (cont) begin
							reps_q <= reps_q + REP_W'(1);
							pend_q <= wc_in;
							if (wc_q != WCOL_MAX)
								wc_q <= wc_q + WCOL_W'(1);
						end else begin
							pend_q <= 1'b0;
							sh_q   <= MOD_SH;
							if (!ge)
								col_acc_q <= wrk_q[ACC_W-1:0];
						end
					end
				end
				ST_PX_MOD: begin
					sh_q <= sh_q - SH_W'(1);
					if (sh_zero)
						col_acc_q <= ge ? alu_rsp.res[ACC_W-1:0] : wrk_q[ACC_W-1:0];
				end
				ST_LN_ADD: sh_q <= DIV_SH;
				ST_LN_DIV: begin
					sh_q <= sh_q - SH_W'(1);
					if (sh_zero)
						row_acc_q <= ge ? alu_rsp.res[ACC_W-1:0] : wrk_q[ACC_W-1:0];
				end
				ST_LN_OUT: begin
					if (ofree) begin
						rows_q    <= rows_sum;
						col_acc_q <= '0;
						wc_q      <= '0;
					end
				end
				ST_EJ_OUT: begin
					if (ofree) begin
						if (ge)
							rows_q <= cfg.page_h;
						active_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (s_valid) pix_q <= s_rgb;
			ST_PX_ADD: wrk_q <= alu_rsp.res[WRK_W-1:0];
			ST_PX_LOOP: begin
				if (adv && cont) begin
					wrk_q      <= alu_rsp.res[WRK_W-1:0];
					pend_col_q <= wc_q[COL_W-1:0];
				end
			end
			ST_PX_MOD: if (ge) wrk_q <= alu_rsp.res[WRK_W-1:0];
			ST_LN_ADD: begin
				wrk_q  <= alu_rsp.res[WRK_W-1:0];
				quot_q <= '0;
			end
			ST_LN_DIV: begin
				if (ge)
					wrk_q <= alu_rsp.res[WRK_W-1:0];
				quot_q <= {quot_q[QUOT_W-2:0], ge};
			end
			default: ;
		endcase
		if (load_out)
			out_q <= out_d;
	end

	assign m_valid = out_valid_q;
	assign m_res   = out_q;

endmodule

// ===== sim/tb_raster_line_dpi_scaler_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_raster_line_dpi_scaler_unit
// Drives raster commands into the scaler and checks every page operation it
// returns against a cycle-free model of the column and row accumulators.
// Register settings cover the default A4 page, up- and downscaling, zero
// source resolution, the repeat limit, the line width limit, row count
// saturation, and full-page eject. Both stream sides idle at random,
// and the result side is held off once long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_raster_line_dpi_scaler_unit;
	import rldpi_pkg::*;

	localparam int SETTLE_CYCLES = 64;
	localparam int CYCLE_LIMIT   = 600000;
	localparam int HOLD_CYCLES   = 400;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [23:0] pix;
	} raster_cmd_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [PADDR_W-1:0]   paddr = '0;
	logic [PDATA_W-1:0]   pwdata = '0;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;

	raster_cmd_t raster_cmds[$];
	res_t        page_ops_due[$];
	raster_cmd_t next_cmd;

	cfg_t        page_cfg;
	int unsigned col_acc, wr_col, row_acc, rows_done;
	bit          page_on;

	bit          in_fire = 1'b0;
	bit          gap_on = 1'b1;
	int          quiet_cycles = 0;
	int          cycles = 0;
	int          stall_reqs = 0;
	int          stall_seen = 0;
	int          hold_left = 0;
	int          mismatches = 0;
	int          n_cmds = 0;
	int          n_settings = 0;
	int          n_px_out = 0;
	int          n_line_out = 0;
	int          n_blank_out = 0;

	raster_line_dpi_scaler_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic scale_request(input logic [1:0] cmd, input logic [23:0] pix);
		res_t        outs [MAX_RESULTS];
		res_t        r;
		int unsigned n, sx, sy, w, reps, pad, copies, first, blanks;
		n = 0;
		w = (int'(page_cfg.page_w) < LINE_PIXELS) ? page_cfg.page_w : LINE_PIXELS;
		case (cmd)
			CMD_PIXEL: begin
				sx = (page_cfg.src_x != 0) ? page_cfg.src_x : 1;
				if (!page_on) begin
					rows_done = 0;
					page_on = 1'b1;
				end
				col_acc += page_cfg.page_x;
				reps = 0;
				while (col_acc >= sx && reps < REP_CAP) begin
					col_acc -= sx;
					reps++;
					if (wr_col < w) begin
						r = '0;
						r.kind = KIND_PIXEL;
						r.column = COL_W'(wr_col);
						r.rgb.red = pix[7:0];
						r.rgb.green = pix[15:8];
						r.rgb.blue = pix[23:16];
						outs[n] = r;
						n++;
					end
					if (wr_col < 8191)
						wr_col++;
				end
				if (col_acc >= sx)
					col_acc = col_acc % sx;
				col_acc &= 32'hfff;
			end
			CMD_LINE: begin
				sy = (page_cfg.src_y != 0) ? page_cfg.src_y : 1;
				pad = (wr_col < w) ? wr_col : w;
				if (!page_on) begin
					rows_done = 0;
					page_on = 1'b1;
				end
				row_acc += page_cfg.page_y;
				copies = row_acc / sy;
				row_acc = row_acc % sy;
				first = rows_done;
				rows_done += copies;
				if (rows_done > 16383)
					rows_done = 16383;
				r = '0;
				r.kind = KIND_LINE;
				r.column = COL_W'(pad);
				r.line_total = ROW_W'(copies);
				r.first_row = ROW_W'(first);
				outs[n] = r;
				n++;
				col_acc = 0;
				wr_col = 0;
			end
			CMD_EJECT: begin
				if (page_on) begin
					blanks = (rows_done < page_cfg.page_h) ? page_cfg.page_h - rows_done : 0;
					r = '0;
					r.kind = KIND_BLANK;
					r.line_total = ROW_W'(blanks);
					r.first_row = ROW_W'(rows_done);
					outs[n] = r;
					n++;
					rows_done += blanks;
					page_on = 1'b0;
				end
			end
			default: begin
			end
		endcase
		for (int i = 0; i < n; i++) begin
			r = outs[i];
			r.last = (i == n - 1);
			page_ops_due.push_back(r);
		end
	endtask

	task automatic cmp_field(input string fname, input int unsigned want, input int unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
		end
	endtask

	task automatic check_page_op;
		res_t want;
		if (page_ops_due.size() == 0) begin
			mismatches++;
			$display("%0t: unexpected result, expected none, actual kind %0d tdata %h", $time,
				m_axis_tuser, m_axis_tdata);
		end else begin
			want = page_ops_due.pop_front();
			cmp_field("kind", want.kind, m_axis_tuser);
			cmp_field("column", want.column, m_axis_tdata[11:0]);
			cmp_field("out_red", want.rgb.red, m_axis_tdata[19:12]);
			cmp_field("out_green", want.rgb.green, m_axis_tdata[27:20]);
			cmp_field("out_blue", want.rgb.blue, m_axis_tdata[35:28]);
			cmp_field("line_total", want.line_total, m_axis_tdata[49:36]);
			cmp_field("first_row", want.first_row, m_axis_tdata[63:50]);
			cmp_field("last", want.last, m_axis_tlast);
			case (want.kind)
				KIND_PIXEL: n_px_out++;
				KIND_LINE:  n_line_out++;
				default:    n_blank_out++;
			endcase
		end
	endtask

	always @(posedge clk) begin
		in_fire = arst_n && s_axis_tvalid && s_axis_tready;
		if (in_fire) begin
			scale_request(s_axis_tuser, s_axis_tdata);
			n_cmds++;
		end
		if (arst_n && m_axis_tvalid && m_axis_tready)
			check_page_op();
		if (raster_cmds.size() == 0 && !s_axis_tvalid && page_ops_due.size() == 0
				&& !m_axis_tvalid)
			quiet_cycles++;
		else
			quiet_cycles = 0;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				page_ops_due.size());
			$display("raster_line_dpi_scaler_unit regression: fail");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || in_fire) begin
			if (raster_cmds.size() > 0 && !(gap_on && $urandom_range(99) < 33)) begin
				next_cmd = raster_cmds.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tuser <= next_cmd.cmd;
				s_axis_tdata <= next_cmd.pix;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (stall_seen != stall_reqs) begin
			stall_seen = stall_reqs;
			hold_left = HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= !(gap_on && $urandom_range(99) < 33);
		end
	end

	task automatic write_reg(input reg_idx_t idx, input int unsigned value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(4 * int'(idx));
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_SRC_X:  page_cfg.src_x = DPI_W'(value);
			REG_SRC_Y:  page_cfg.src_y = DPI_W'(value);
			REG_PAGE_X: page_cfg.page_x = DPI_W'(value);
			REG_PAGE_Y: page_cfg.page_y = DPI_W'(value);
			REG_PAGE_W: page_cfg.page_w = PW_W'(value);
			REG_PAGE_H: page_cfg.page_h = PH_W'(value);
			default: begin
			end
		endcase
	endtask

	task automatic set_page(input int unsigned sx, input int unsigned sy, input int unsigned px,
			input int unsigned py, input int unsigned pw, input int unsigned ph);
		write_reg(REG_SRC_X, sx);
		write_reg(REG_SRC_Y, sy);
		write_reg(REG_PAGE_X, px);
		write_reg(REG_PAGE_Y, py);
		write_reg(REG_PAGE_W, pw);
		write_reg(REG_PAGE_H, ph);
		n_settings++;
	endtask

	task automatic random_page;
		int unsigned sx, sy, px, py, pw;
		sx = ($urandom_range(7) == 0) ? $urandom_range(2047) : $urandom_range(75, 1200);
		sy = ($urandom_range(7) == 0) ? $urandom_range(2047) : $urandom_range(75, 1200);
		px = ($urandom_range(7) == 0) ? $urandom_range(2047) : $urandom_range(1, 1200);
		py = ($urandom_range(7) == 0) ? $urandom_range(2047) : $urandom_range(1, 1200);
		pw = ($urandom_range(3) == 0) ? $urandom_range(1, 8191) : $urandom_range(1, 64);
		set_page(sx, sy, px, py, pw, $urandom_range(1, 16383));
	endtask

	task automatic add_req(input logic [1:0] cmd, input logic [23:0] pix);
		raster_cmd_t c;
		c.cmd = cmd;
		c.pix = pix;
		raster_cmds.push_back(c);
	endtask

	task automatic queue_random_lines(input int target);
		int          count;
		int unsigned pick, npix;
		logic [1:0]  cmd;
		count = 0;
		while (count < target) begin
			pick = $urandom_range(99);
			if (pick < 75) begin
				npix = $urandom_range(10);
				repeat (npix) add_req(CMD_PIXEL, 24'($urandom));
				add_req(CMD_LINE, 24'($urandom));
				count += npix + 1;
			end else if (pick < 85) begin
				add_req(CMD_EJECT, 24'($urandom));
				count++;
			end else begin
				cmd = 2'($urandom_range(3));
				add_req(cmd, 24'($urandom));
				if (cmd != 2'd3)
					count++;
			end
		end
	endtask

	task automatic wait_quiet;
		do
			@(negedge clk);
		while (quiet_cycles < SETTLE_CYCLES);
	endtask

	initial begin
		page_cfg.src_x = RST_SRC_X;
		page_cfg.src_y = RST_SRC_Y;
		page_cfg.page_x = RST_PAGE_X;
		page_cfg.page_y = RST_PAGE_Y;
		page_cfg.page_w = RST_PAGE_W;
		page_cfg.page_h = RST_PAGE_H;
		col_acc = 0;
		wr_col = 0;
		row_acc = 0;
		rows_done = 0;
		page_on = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		n_settings = 1;

		// default page: eject with no page, unknown command, color extremes
		add_req(CMD_EJECT, 24'h000000);
		add_req(2'd3, 24'h123456);
		add_req(CMD_PIXEL, 24'h000000);
		add_req(CMD_PIXEL, 24'hffffff);
		add_req(CMD_PIXEL, 24'h0f55aa);
		add_req(CMD_LINE, 24'h000000);
		add_req(CMD_LINE, 24'hffffff);
		add_req(CMD_EJECT, 24'h000000);
		add_req(CMD_EJECT, 24'h000000);
		add_req(2'd3, 24'hffffff);
		wait_quiet();

		// upscale past a narrow page, then eject a page already full
		set_page(75, 75, 300, 1200, 6, 1);
		add_req(CMD_PIXEL, 24'ha5c33c);
		add_req(CMD_PIXEL, 24'h5a3cc3);
		add_req(CMD_LINE, 24'h000000);
		add_req(CMD_EJECT, 24'h000000);
		wait_quiet();

		// zero source resolution, repeat limit, row count saturation
		set_page(0, 0, 2047, 2047, 8191, 16383);
		add_req(CMD_PIXEL, 24'h807f01);
		repeat (9) add_req(CMD_LINE, 24'h000000);
		add_req(CMD_EJECT, 24'h000000);
		wait_quiet();

		// full-rate line running past the page width, no idling
		gap_on = 1'b0;
		set_page(75, 300, 1200, 300, 200, 3508);
		repeat (14) add_req(CMD_PIXEL, 24'($urandom));
		add_req(CMD_LINE, 24'h000000);
		add_req(CMD_EJECT, 24'h000000);
		wait_quiet();
		gap_on = 1'b1;

		for (int ph = 0; ph < 5; ph++) begin
			if (ph == 4)
				set_page(1200, 1200, 1, 1, 1, 1);
			else
				random_page();
			queue_random_lines(24);
			if (ph == 0)
				stall_reqs++;
			wait_quiet();
		end

		$display("covered %0d requests over %0d register settings", n_cmds, n_settings);
		$display("checked %0d pixel writes, %0d line ends, %0d page fills", n_px_out,
			n_line_out, n_blank_out);
		if (mismatches == 0)
			$display("raster_line_dpi_scaler_unit regression: pass");
		else
			$display("raster_line_dpi_scaler_unit regression: fail");
		$finish;
	end

endmodule

// ===== raster_line_dpi_scaler_unit.f =====
rtl/rldpi_pkg.sv
rtl/rldpi_alu.sv
rtl/rldpi_cfg.sv
rtl/rldpi_ctrl.sv
rtl/raster_line_dpi_scaler_unit.sv
sim/tb_raster_line_dpi_scaler_unit.sv
